/* design/mtt_pkg.sv */
// Shared types and constants of the timer table.
// Used by the slot store, the period unit and the top level.
`default_nettype none

package mtt_pkg;

	localparam int CNT_W  = 23;
	localparam int REP_W  = 32;
	localparam int ID_W   = 5;
	localparam int MASK_W = 16;
	localparam int INTV_W = 32;

	// Create only claims slots whose id still fits the id field.
	localparam int MAX_ID_SLOTS = 31;

	// interval / 1000 as (interval * RECIP_MULT) >> RECIP_SHIFT, exact for 32-bit input
	localparam int          RECIP_W     = 29;
	localparam int          RECIP_SHIFT = 38;
	localparam int          PROD_W      = INTV_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_MULT = 29'h1062_4DD3;

	localparam logic [REP_W-1:0] REPEAT_FOREVER = '1;

	localparam logic [1:0] SLOT_FREE    = 2'd0;
	localparam logic [1:0] SLOT_CREATED = 2'd1;
	localparam logic [1:0] SLOT_RUNNING = 2'd2;

	typedef enum logic [2:0] {
		MODE_TICK    = 3'd0,
		MODE_CREATE  = 3'd1,
		MODE_DESTROY = 3'd2,
		MODE_START   = 3'd3,
		MODE_STOP    = 3'd4
	} mode_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] period;
		logic [REP_W-1:0] repeats;
		logic             callback;
	} slot_t;

endpackage

`default_nettype wire

/* design/mtt_store.sv */
// Slot store: one synchronous memory of slot entries with a registered read.
// Per-entry valid flops make unwritten entries read as all zero. Uses mtt_pkg.
`default_nettype none

module mtt_store #(
	parameter int NUM_TIMERS = 16,
	parameter int AW = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output mtt_pkg::slot_t  rd_data,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  mtt_pkg::slot_t  wr_data
);
	import mtt_pkg::*;

	slot_t                 mem [NUM_TIMERS];
	slot_t                 rd_data_q;
	logic [NUM_TIMERS-1:0] valid_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	// never-written entry reads as all zero
	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

/* design/mtt_period.sv */
// Period unit: interval in microseconds to ticks, divided by 1000, at least 1.
// Reciprocal multiply with a registered product. Uses mtt_pkg.
`default_nettype none

module mtt_period (
	input  logic                        clk,
	input  logic [mtt_pkg::INTV_W-1:0]  interval,
	output logic [mtt_pkg::CNT_W-1:0]   period
);
	import mtt_pkg::*;

	logic [PROD_W-1:0] prod_q;
	logic [CNT_W-1:0]  quot;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(interval) * PROD_W'(RECIP_MULT);
	end

	assign quot   = prod_q[RECIP_SHIFT +: CNT_W];
	assign period = (quot == '0) ? CNT_W'(1) : quot;

endmodule

`default_nettype wire

/* design/multi_timer_table_top.sv */
// multi_timer_table_top: table of periodic timers, one result item per input item.
// The slot walk over the store, one slot per cycle, covers every slot for a tick,
// up to min(NUM_TIMERS,31) slots for a create, the named slot for destroy/start/stop
// and no slot for ignored items. The next item is taken in the cycle after its
// result is loaded.
// Reset clears control state and the store's valid bits at once; no clearing pass.
`default_nettype none

module multi_timer_table_top #(
	parameter int NUM_TIMERS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  mode,
	input  logic [mtt_pkg::ID_W-1:0]    timer_id,
	input  logic [mtt_pkg::INTV_W-1:0]  interval_us,
	input  logic [mtt_pkg::REP_W-1:0]   repeat_count,
	input  logic                        has_callback,
	// output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mtt_pkg::ID_W-1:0]    new_timer_id,
	output logic [mtt_pkg::MASK_W-1:0]  fire_mask
);
	import mtt_pkg::*;

	localparam int AW           = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CREATE_SLOTS = (NUM_TIMERS < MAX_ID_SLOTS) ? NUM_TIMERS : MAX_ID_SLOTS;
	localparam logic [AW-1:0] LAST_SLOT   = AW'(NUM_TIMERS - 1);
	localparam logic [AW-1:0] CREATE_LAST = AW'(CREATE_SLOTS - 1);

	// one-hot sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} seq_state_t;

	seq_state_t          state_q;

	// latched item
	logic [2:0]          mode_q;
	logic [REP_W-1:0]    reps_q;
	logic                cb_q;
	logic [INTV_W-1:0]   interval_q;

	// walk control: idx_q is the next read, the _s1 stage holds the read in flight
	logic [AW-1:0]       idx_q;
	logic [AW-1:0]       last_q;
	logic                issue_q;
	logic                vld_s1;
	logic [AW-1:0]       addr_s1;

	// result being built and the output register
	logic [ID_W-1:0]     res_id_q;
	logic [MASK_W-1:0]   res_mask_q;
	logic                out_valid_q;
	logic [ID_W-1:0]     out_id_q;
	logic [MASK_W-1:0]   out_mask_q;

	// store port
	slot_t               rd_data;
	slot_t               wr_data;
	logic                wr_en;

	logic [CNT_W-1:0]    period;
	logic [CNT_W-1:0]    cnt_inc;
	logic                fire;
	logic                found;
	logic                step_last;
	logic                in_take;
	logic                out_free;
	logic                id_ok;
	logic [AW-1:0]       id_slot;

	mtt_store #(
		.NUM_TIMERS (NUM_TIMERS),
		.AW         (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (issue_q),
		.rd_addr (idx_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (wr_data)
	);

	// interval_q is set at accept; the period is ready when the first entry returns
	mtt_period u_period (
		.clk      (clk),
		.interval (interval_q),
		.period   (period)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign id_ok   = (timer_id != '0) && (32'(timer_id) <= NUM_TIMERS);
	assign id_slot = AW'(timer_id - ID_W'(1));

	assign cnt_inc = rd_data.count + CNT_W'(1);

	// modify the entry that came back from the store
	always_comb begin
		wr_data = rd_data;
		wr_en   = 1'b0;
		fire    = 1'b0;
		found   = 1'b0;
		unique case (mode_q)
			MODE_TICK: begin
				if (rd_data.status == SLOT_RUNNING) begin
					wr_en = vld_s1;
					if (cnt_inc < rd_data.period) begin
						wr_data.count = cnt_inc;
					end else begin
						// period reached: restart the count, fire while repeats remain
						wr_data.count = '0;
						if (rd_data.repeats == REPEAT_FOREVER) begin
							fire = 1'b1;
						end else if (rd_data.repeats != '0) begin
							wr_data.repeats = rd_data.repeats - REP_W'(1);
							fire            = 1'b1;
						end
					end
				end
			end
			MODE_CREATE: begin
				if (rd_data.status == SLOT_FREE) begin
					found            = 1'b1;
					wr_en            = vld_s1;
					wr_data.status   = SLOT_CREATED;
					wr_data.callback = cb_q;
					wr_data.period   = period;
				end
			end
			MODE_DESTROY: begin
				// count and repeats stay behind
				wr_en            = vld_s1;
				wr_data.status   = SLOT_FREE;
				wr_data.callback = 1'b0;
				wr_data.period   = '0;
			end
			MODE_START: begin
				wr_en           = vld_s1;
				wr_data.status  = SLOT_RUNNING;
				wr_data.count   = '0;
				wr_data.repeats = reps_q;
			end
			MODE_STOP: begin
				wr_en          = vld_s1;
				wr_data.status = SLOT_CREATED;
			end
			default: begin
			end
		endcase
	end

	// walk ends on the last slot in range, or at the first free slot for create
	assign step_last = vld_s1 && ((addr_s1 == last_q) || (mode_q == MODE_CREATE && found));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// drop a taken result unless the done state reloads it in this cycle
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						unique case (mode)
							MODE_TICK, MODE_CREATE: begin
								issue_q <= 1'b1;
								state_q <= ST_WALK;
							end
							MODE_DESTROY, MODE_START, MODE_STOP: begin
								// bad id: nothing to touch
								issue_q <= id_ok;
								state_q <= id_ok ? ST_WALK : ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_WALK: begin
					vld_s1 <= issue_q && !step_last;
					if (step_last || (issue_q && idx_q == last_q)) begin
						issue_q <= 1'b0;
					end
					if (step_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_q     <= mode;
			reps_q     <= repeat_count;
			cb_q       <= has_callback;
			interval_q <= interval_us;
			res_id_q   <= '0;
			res_mask_q <= '0;
			unique case (mode)
				MODE_TICK: begin
					idx_q  <= '0;
					last_q <= LAST_SLOT;
				end
				MODE_CREATE: begin
					idx_q  <= '0;
					last_q <= CREATE_LAST;
				end
				default: begin
					idx_q  <= id_slot;
					last_q <= id_slot;
				end
			endcase
		end else if (state_q == ST_WALK) begin
			if (issue_q && idx_q != last_q) begin
				idx_q <= AW'(idx_q + AW'(1));
			end
			addr_s1 <= idx_q;
			if (vld_s1 && mode_q == MODE_CREATE && found) begin
				res_id_q <= ID_W'(32'(addr_s1) + 1);
			end
			// only the low slots appear in the mask
			if (vld_s1 && mode_q == MODE_TICK && fire && rd_data.callback
					&& 32'(addr_s1) < MASK_W) begin
				res_mask_q <= res_mask_q | (MASK_W'(1) << addr_s1);
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_id_q   <= res_id_q;
			out_mask_q <= res_mask_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign new_timer_id = out_id_q;
	assign fire_mask    = out_mask_q;

	// a result is only loaded from the done state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the done state");

	// a created id always names a slot create may claim
	a_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_id_q != '0 |-> 32'(out_id_q) <= CREATE_SLOTS)
		else $error("created id out of range");

	// one result carries an id or a mask, never both
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_id_q == '0) || (out_mask_q == '0))
		else $error("id and mask both set");

	// the last slot of the walk ends it in the next cycle
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK && vld_s1 && addr_s1 == last_q |=> state_q == ST_DONE)
		else $error("walk ran past its last slot");

endmodule

`default_nettype wire

/* test/mtt_check_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the timer table bench: a slot-level copy of the table that
// predicts one response per accepted command and checks responses in order.
// Depends on mtt_pkg for widths, slot states and mode codes.

package mtt_check_pkg;

	import mtt_pkg::*;

	localparam int                TABLE_SLOTS      = 16;
	localparam logic [INTV_W-1:0] US_PER_TICK      = 1000;
	localparam logic [2:0]        MODE_SPARE_FIRST = 3'd5;
	localparam logic [2:0]        MODE_SPARE_LAST  = 3'd7;
	localparam int                SHOWN_MISMATCHES = 10;

	typedef struct {
		logic [ID_W-1:0]   new_id;
		logic [MASK_W-1:0] mask;
	} response_t;

	class timer_table_scoreboard;
		logic [1:0]       status   [TABLE_SLOTS];
		logic [CNT_W-1:0] count    [TABLE_SLOTS];
		logic [CNT_W-1:0] period   [TABLE_SLOTS];
		logic [REP_W-1:0] repeats  [TABLE_SLOTS];
		logic             callback [TABLE_SLOTS];
		response_t        due_responses [$];
		int               errors;

		function new();
			int s;
			errors = 0;
			for (s = 0; s < TABLE_SLOTS; s++) begin
				status[s]   = SLOT_FREE;
				count[s]    = '0;
				period[s]   = '0;
				repeats[s]  = '0;
				callback[s] = 1'b0;
			end
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= SHOWN_MISMATCHES) begin
				$display("%0t: mismatch: %s", $time, msg);
			end
		endfunction

		function int pending();
			return due_responses.size();
		endfunction

		// lowest free slot whose id still fits the id field
		function logic [ID_W-1:0] claim_slot(logic [INTV_W-1:0] interval, logic cb);
			logic [INTV_W-1:0] ticks;
			logic [ID_W-1:0]   id;
			int                s;
			int                last;
			ticks = interval / US_PER_TICK;
			if (ticks == '0) begin
				ticks = 1;
			end
			last = (TABLE_SLOTS < MAX_ID_SLOTS) ? TABLE_SLOTS : MAX_ID_SLOTS;
			for (s = 0; s < last; s++) begin
				if (status[s] == SLOT_FREE) begin
					status[s]   = SLOT_CREATED;
					callback[s] = cb;
					period[s]   = ticks[CNT_W-1:0];
					id          = ID_W'(s + 1);
					return id;
				end
			end
			return '0;
		endfunction

		function logic [MASK_W-1:0] step_timers();
			logic [MASK_W-1:0] mask;
			logic              fired;
			int                s;
			mask = '0;
			for (s = 0; s < TABLE_SLOTS; s++) begin
				if (status[s] == SLOT_RUNNING) begin
					count[s] = count[s] + 1'b1;
					if (count[s] >= period[s]) begin
						count[s] = '0;
						fired    = 1'b0;
						if (repeats[s] == REPEAT_FOREVER) begin
							fired = 1'b1;
						end else if (repeats[s] != '0) begin
							repeats[s] = repeats[s] - 1'b1;
							fired      = 1'b1;
						end
						if (fired && callback[s] && s < MASK_W) begin
							mask[s] = 1'b1;
						end
					end
				end
			end
			return mask;
		endfunction

		function void take_command(logic [2:0] cmd_mode, logic [ID_W-1:0] id,
				logic [INTV_W-1:0] interval, logic [REP_W-1:0] reps, logic cb);
			response_t rsp;
			logic      id_ok;
			int        s;
			rsp.new_id = '0;
			rsp.mask   = '0;
			id_ok = (id != '0) && (id <= TABLE_SLOTS);
			s     = id_ok ? int'(id) - 1 : 0;
			case (cmd_mode)
				MODE_TICK: begin
					rsp.mask = step_timers();
				end
				MODE_CREATE: begin
					rsp.new_id = claim_slot(interval, cb);
				end
				MODE_DESTROY: begin
					if (id_ok) begin
						status[s]   = SLOT_FREE;
						callback[s] = 1'b0;
						period[s]   = '0;
					end
				end
				MODE_START: begin
					if (id_ok) begin
						status[s]  = SLOT_RUNNING;
						count[s]   = '0;
						repeats[s] = reps;
					end
				end
				MODE_STOP: begin
					if (id_ok) begin
						status[s] = SLOT_CREATED;
					end
				end
				default: begin
				end
			endcase
			due_responses.push_back(rsp);
		endfunction

		function void match_response(logic [ID_W-1:0] new_id, logic [MASK_W-1:0] mask);
			response_t want;
			if (due_responses.size() == 0) begin
				flag($sformatf("response with none pending: new_timer_id %0d fire_mask %h",
					new_id, mask));
				return;
			end
			want = due_responses.pop_front();
			if (new_id !== want.new_id) begin
				flag($sformatf("new_timer_id expected %0d, got %0d", want.new_id, new_id));
			end
			if (mask !== want.mask) begin
				flag($sformatf("fire_mask expected %h, got %h", want.mask, mask));
			end
		endfunction
	endclass

endpackage

/* test/tb_multi_timer_table_top.sv */
`timescale 1ns / 100ps
// Bench for multi_timer_table_top: directed and random commands through the
// valid/stall channels, responses checked against mtt_check_pkg's scoreboard.
// Depends on mtt_pkg, mtt_check_pkg and the design sources.

module tb_multi_timer_table_top;

	import mtt_pkg::*;
	import mtt_check_pkg::*;

	localparam int RANDOM_ITEMS = 1825;
	localparam int IDLE_PCT     = 16;
	// slowest item walks every slot, as a tick does; stalls and gaps add to it
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 2 * TABLE_SLOTS + 8;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         mode;
	logic [ID_W-1:0]    timer_id;
	logic [INTV_W-1:0]  interval_us;
	logic [REP_W-1:0]   repeat_count;
	logic               has_callback;
	logic               out_valid;
	logic               out_stall;
	logic [ID_W-1:0]    new_timer_id;
	logic [MASK_W-1:0]  fire_mask;

	// set during a stretch of the random part: neither side idles then
	bit                 calm_phase;
	int unsigned        cycles;

	timer_table_scoreboard board;

	multi_timer_table_top #(
		.NUM_TIMERS(TABLE_SLOTS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.timer_id     (timer_id),
		.interval_us  (interval_us),
		.repeat_count (repeat_count),
		.has_callback (has_callback),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.new_timer_id (new_timer_id),
		.fire_mask    (fire_mask)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Count cycles for the watchdog below.
	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("tb_multi_timer_table_top: errors");
		$finish;
	end

	// Receiver: raise stall at random on the falling edge, hold it through
	// the calm stretch at zero.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = !calm_phase && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Check every response taken at a rising edge against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			board.match_response(new_timer_id, fire_mask);
		end
	end

	// Drive one command: idle at random first, then present it on the
	// falling edge and hold it until a rising edge sees stall low.
	task automatic send_item(input logic [2:0] m, input logic [ID_W-1:0] id,
			input logic [INTV_W-1:0] iv, input logic [REP_W-1:0] rc, input logic cb);
		@(negedge clk);
		while (!calm_phase && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		mode         = m;
		timer_id     = id;
		interval_us  = iv;
		repeat_count = rc;
		has_callback = cb;
		in_valid     = 1'b1;
		do @(posedge clk); while (in_stall);
		board.take_command(m, id, iv, rc, cb);
	endtask

	initial begin
		int                sent;
		int                roll;
		int                pick;
		logic [2:0]        m;
		logic [ID_W-1:0]   id;
		logic [INTV_W-1:0] iv;
		logic [REP_W-1:0]  rc;
		logic              cb;
		bit                fill;

		board        = new();
		calm_phase   = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = MODE_TICK;
		timer_id     = '0;
		interval_us  = '0;
		repeat_count = '0;
		has_callback = 1'b0;

		// Hold reset low, then release it away from the rising edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part.
		// Tick an empty table, then the unused modes with every field set.
		send_item(MODE_TICK, '0, '0, '0, 1'b0);
		send_item(MODE_SPARE_FIRST, '1, '1, '1, 1'b1);
		send_item(MODE_SPARE_FIRST + 3'd1, '1, '1, '1, 1'b1);
		send_item(MODE_SPARE_LAST, '1, '1, '1, 1'b1);
		// Create: zero interval rounds up to one tick, all ones gives the
		// longest period, 2999 us truncates to two ticks.
		send_item(MODE_CREATE, '0, '0, '0, 1'b1);
		send_item(MODE_CREATE, '0, '1, '0, 1'b1);
		send_item(MODE_CREATE, '0, 32'd2999, '0, 1'b1);
		// Limited and unlimited repeats.
		send_item(MODE_START, 5'd1, '0, 32'd2, 1'b0);
		send_item(MODE_START, 5'd3, '0, REPEAT_FOREVER, 1'b0);
		// Start on a never-created slot runs with period zero; stop on a free
		// slot takes it away from create.
		send_item(MODE_START, 5'd10, '0, 32'd3, 1'b0);
		send_item(MODE_STOP, 5'd12, '0, '0, 1'b0);
		// Ids zero and past the table do nothing.
		send_item(MODE_START, 5'd0, '0, 32'd5, 1'b1);
		send_item(MODE_STOP, 5'd17, '0, '0, 1'b0);
		send_item(MODE_DESTROY, '1, '0, '0, 1'b0);
		// Run slot 0 out of repeats.
		send_item(MODE_TICK, '0, '0, '0, 1'b0);
		send_item(MODE_TICK, '0, '0, '0, 1'b0);
		send_item(MODE_TICK, '0, '0, '0, 1'b0);
		send_item(MODE_START, 5'd2, '0, '0, 1'b0);
		// Destroy keeps count and repeats; create reclaims the slot.
		send_item(MODE_DESTROY, 5'd3, '0, '0, 1'b0);
		send_item(MODE_CREATE, '0, 32'd1000, '0, 1'b0);
		send_item(MODE_START, 5'd3, '0, 32'd1, 1'b0);
		send_item(MODE_TICK, '0, '0, '0, 1'b0);
		send_item(MODE_STOP, 5'd1, '0, '0, 1'b0);
		send_item(MODE_TICK, '0, '0, '0, 1'b0);
		send_item(MODE_CREATE, '0, 32'd1999, '0, 1'b1);

		// Random part: mostly short periods and small repeat budgets so timers
		// fire and run dry, some create-heavy chunks that fill the table, and
		// a share of noise (spare modes, bad ids).
		sent = 0;
		fill = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 60 == 0) begin
				fill = ($urandom_range(0, 3) == 0);
			end
			calm_phase = (sent >= 700 && sent < 1000);

			id = ID_W'($urandom_range(1, TABLE_SLOTS));
			if ($urandom_range(0, 9) == 0) begin
				id = ID_W'($urandom_range(0, 1) ? 0 :
					$urandom_range(TABLE_SLOTS + 1, (1 << ID_W) - 1));
			end

			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				iv = $urandom_range(0, 6999);
			end else if (pick < 85) begin
				iv = $urandom_range(7000, 60000);
			end else if (pick < 95) begin
				iv = $urandom_range(0, 999);
			end else begin
				iv = $urandom;
			end

			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				rc = $urandom_range(0, 4);
			end else if (pick < 75) begin
				rc = $urandom_range(5, 40);
			end else if (pick < 88) begin
				rc = REPEAT_FOREVER;
			end else begin
				rc = $urandom;
			end

			cb   = 1'($urandom_range(0, 1));
			roll = $urandom_range(0, 99);
			if (fill && roll < 40) begin
				m = MODE_CREATE;
			end else if (roll < 50) begin
				m = MODE_TICK;
			end else if (roll < 64) begin
				m = MODE_CREATE;
			end else if (roll < 72) begin
				m = MODE_DESTROY;
			end else if (roll < 86) begin
				m = MODE_START;
			end else if (roll < 94) begin
				m = MODE_STOP;
			end else begin
				m = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
			end

			send_item(m, id, iv, rc, cb);
			sent++;
		end
		calm_phase = 1'b0;

		// Drop valid, drain the responses, then give the block time to show
		// any stray response.
		@(negedge clk);
		in_valid = 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (board.errors == 0) begin
			$display("tb_multi_timer_table_top: clean");
		end else begin
			$display("tb_multi_timer_table_top: errors");
		end
		$finish;
	end

endmodule
